// ===== hdl/ptt_pkg.sv =====
// Shared types and constants for the periodic timer table.
package ptt_pkg;

  localparam int unsigned NOW_W       = 48;
  localparam int unsigned PERIOD_W    = 22;
  localparam int unsigned TAG_W       = 8;
  localparam int unsigned MINUTES_W   = 16;
  localparam int unsigned CAP_W       = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned FIRE_W      = $clog2(MAX_RESULTS + 1);
  localparam int unsigned SEC_PER_MIN = 60;
  localparam logic [CAP_W-1:0] DEFAULT_CAP = 16'd10;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    KIND_ADDED = 3'd0,
    KIND_FULL  = 3'd1,
    KIND_FIRED = 3'd2,
    KIND_NONE  = 3'd3,
    KIND_WAIT  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [NOW_W-1:0]    deadline;
    logic [PERIOD_W-1:0] period;
    logic                periodic;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  // Decision of the head unit for the entry at the front of the chain.
  typedef struct packed {
    logic             fire;
    logic             keep;
    entry_t           entry;
    logic [NOW_W-1:0] best;
  } head_t;

endpackage

// ===== hdl/ptt_cell.sv =====
// One timer slot of the chain: load a new entry or take the neighbor's entry.
module ptt_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            shift_i,
  input  ptt_pkg::entry_t load_data_i,
  input  ptt_pkg::entry_t next_data_i,
  output ptt_pkg::entry_t data_o
);

  ptt_pkg::entry_t data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= next_data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== hdl/ptt_head.sv =====
// Head unit: judge the front entry, reschedule it and track the earliest deadline.
module ptt_head (
  input  ptt_pkg::entry_t                head_i,
  input  logic [ptt_pkg::NOW_W-1:0]      now_i,
  input  logic                           tick_i,
  input  logic [ptt_pkg::FIRE_W-1:0]     fired_i,
  input  logic [ptt_pkg::NOW_W-1:0]      best_i,
  output ptt_pkg::head_t                 res_o
);

  logic due;

  always_comb begin
    due = tick_i && (fired_i < ptt_pkg::FIRE_W'(ptt_pkg::MAX_RESULTS))
          && (head_i.deadline <= now_i);
    res_o.fire  = due;
    res_o.keep  = !(due && !head_i.periodic);
    res_o.entry = head_i;
    if (due && head_i.periodic) begin
      res_o.entry.deadline = now_i + ptt_pkg::NOW_W'(head_i.period);
    end
    res_o.best = (head_i.deadline < best_i) ? head_i.deadline : best_i;
  end

endmodule

// ===== hdl/periodic_timer_table.sv =====
// Top level of the periodic timer table: control, chain of timer cells, result register.
// An accepted add gives its result in the cycle after start; tick and query walk
//   the N timers held, one entry per cycle as the list shifts past the head unit.
// Busy stays high through a walk and its closing state; an add leaves it low.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset: list empty, time zero, wait cap 10; timer slots keep no reset value.
module periodic_timer_table #(
  parameter int unsigned TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [15:0] delay_minutes_i,
  input  logic        repeat_timer_i,
  input  logic [7:0]  timer_tag_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [7:0]  fired_tag_o,
  output logic [15:0] wait_seconds_o,
  output logic        last_o
);

  localparam int unsigned CW = $clog2(TIMERS + 1);
  localparam int unsigned NW = ptt_pkg::NOW_W;

  ptt_pkg::state_e state_q, state_d;
  ptt_pkg::func_e  op_q, op_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   step_q, step_d;
  logic [NW-1:0]   now_q, now_d;
  logic [NW-1:0]   best_q, best_d;
  logic [ptt_pkg::FIRE_W-1:0] fired_q, fired_d;
  logic            pend_v_q, pend_v_d;
  logic [ptt_pkg::TAG_W-1:0] pend_tag_q, pend_tag_d;
  logic [ptt_pkg::CAP_W-1:0] cap_q;

  logic            out_v_q, out_v_d;
  ptt_pkg::kind_e  kind_q, kind_d;
  logic [ptt_pkg::TAG_W-1:0] tag_q, tag_d;
  logic [ptt_pkg::CAP_W-1:0] wait_q, wait_d;
  logic            last_q, last_d;

  logic            accept;
  logic [TIMERS-1:0] load;
  logic            shift;
  ptt_pkg::entry_t load_data;
  ptt_pkg::entry_t new_entry;
  ptt_pkg::entry_t cells [TIMERS];
  ptt_pkg::head_t  head;
  logic [NW-1:0]   diff;

  assign accept = start && !busy;
  assign busy   = (state_q != ptt_pkg::ST_IDLE);

  // Period in seconds: minutes times sixty always fits the period width.
  always_comb begin
    new_entry.deadline = '0;
    new_entry.period   = ptt_pkg::PERIOD_W'(delay_minutes_i) *
                         ptt_pkg::PERIOD_W'(ptt_pkg::SEC_PER_MIN);
    new_entry.periodic = repeat_timer_i;
    new_entry.tag      = timer_tag_i;
  end

  // Chain of slots: each cycle of a walk every slot takes its right neighbor,
  // and a kept head entry is written back behind the current list tail.
  for (genvar g = 0; g < TIMERS; g++) begin : g_cell
    ptt_pkg::entry_t nb;
    if (g == TIMERS - 1) begin : g_tail
      assign nb = load_data;
    end else begin : g_mid
      assign nb = cells[g+1];
    end
    ptt_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (load[g]),
      .shift_i     (shift),
      .load_data_i (load_data),
      .next_data_i (nb),
      .data_o      (cells[g])
    );
  end

  ptt_head u_head (
    .head_i  (cells[0]),
    .now_i   (now_q),
    .tick_i  (op_q == ptt_pkg::FUNC_TICK),
    .fired_i (fired_q),
    .best_i  (best_q),
    .res_o   (head)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptt_pkg::ST_IDLE: begin
        if (accept && (func_i == ptt_pkg::FUNC_TICK || func_i == ptt_pkg::FUNC_QUERY)) begin
          state_d = (cnt_q == '0) ? ptt_pkg::ST_DONE : ptt_pkg::ST_WALK;
        end
      end
      ptt_pkg::ST_WALK: begin
        if (step_q == CW'(1)) begin
          state_d = ptt_pkg::ST_DONE;
        end
      end
      ptt_pkg::ST_DONE: state_d = ptt_pkg::ST_IDLE;
      default:          state_d = ptt_pkg::ST_IDLE;
    endcase
  end

  assign diff = best_q - now_q;

  // Datapath and results.
  always_comb begin
    op_d       = op_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    now_d      = now_q;
    best_d     = best_q;
    fired_d    = fired_q;
    pend_v_d   = pend_v_q;
    pend_tag_d = pend_tag_q;
    out_v_d    = 1'b0;
    kind_d     = kind_q;
    tag_d      = '0;
    wait_d     = '0;
    last_d     = 1'b0;
    load       = '0;
    shift      = 1'b0;
    load_data  = head.entry;

    unique case (state_q)
      ptt_pkg::ST_IDLE: begin
        if (accept) begin
          case (func_i)
            ptt_pkg::FUNC_ADD: begin
              out_v_d = 1'b1;
              last_d  = 1'b1;
              if (cnt_q >= CW'(TIMERS)) begin
                kind_d = ptt_pkg::KIND_FULL;
              end else begin
                kind_d    = ptt_pkg::KIND_ADDED;
                load_data = new_entry;
                cnt_d     = cnt_q + CW'(1);
                for (int i = 0; i < TIMERS; i++) begin
                  load[i] = (cnt_q == CW'(i));
                end
              end
            end
            ptt_pkg::FUNC_TICK: begin
              op_d     = ptt_pkg::FUNC_TICK;
              now_d    = now_q + NW'(1);
              step_d   = cnt_q;
              fired_d  = '0;
              pend_v_d = 1'b0;
            end
            ptt_pkg::FUNC_QUERY: begin
              op_d   = ptt_pkg::FUNC_QUERY;
              step_d = cnt_q;
              best_d = '1;
            end
            default: ;  // drop unknown codes
          endcase
        end
      end
      ptt_pkg::ST_WALK: begin
        shift  = 1'b1;
        step_d = step_q - CW'(1);
        best_d = head.best;
        for (int i = 0; i < TIMERS; i++) begin
          load[i] = head.keep && (cnt_q == CW'(i + 1));
        end
        if (!head.keep) begin
          cnt_d = cnt_q - CW'(1);
        end
        if (head.fire) begin
          fired_d    = fired_q + ptt_pkg::FIRE_W'(1);
          pend_v_d   = 1'b1;
          pend_tag_d = head.entry.tag;
          // Release the previous fire now; the final one waits for its last flag.
          if (pend_v_q) begin
            out_v_d = 1'b1;
            kind_d  = ptt_pkg::KIND_FIRED;
            tag_d   = pend_tag_q;
          end
        end
      end
      ptt_pkg::ST_DONE: begin
        out_v_d = 1'b1;
        last_d  = 1'b1;
        if (op_q == ptt_pkg::FUNC_TICK) begin
          pend_v_d = 1'b0;
          if (pend_v_q) begin
            kind_d = ptt_pkg::KIND_FIRED;
            tag_d  = pend_tag_q;
          end else begin
            kind_d = ptt_pkg::KIND_NONE;
          end
        end else begin
          kind_d = ptt_pkg::KIND_WAIT;
          if (cnt_q == '0) begin
            wait_d = cap_q;
          end else if (best_q <= now_q) begin
            wait_d = '0;
          end else if (diff > NW'(cap_q)) begin
            wait_d = cap_q;
          end else begin
            wait_d = diff[ptt_pkg::CAP_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ptt_pkg::ST_IDLE;
      op_q     <= ptt_pkg::FUNC_TICK;
      cnt_q    <= '0;
      step_q   <= '0;
      now_q    <= '0;
      fired_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      cap_q    <= ptt_pkg::DEFAULT_CAP;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      cnt_q    <= cnt_d;
      step_q   <= step_d;
      now_q    <= now_d;
      fired_q  <= fired_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Payload registers: hold their value without reset.
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    pend_tag_q <= pend_tag_d;
    kind_q     <= kind_d;
    tag_q      <= tag_d;
    wait_q     <= wait_d;
    last_q     <= last_d;
  end

  assign result_valid_o = out_v_q;
  assign kind_o         = kind_q;
  assign fired_tag_o    = tag_q;
  assign wait_seconds_o = wait_q;
  assign last_o         = last_q;

  // The list never holds more than the number of slots.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TIMERS))
    else $error("entry count exceeds slot count");

  // Steps left in a walk never exceed the live list length.
  a_walk_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptt_pkg::ST_WALK) |-> (step_q != '0 && step_q <= cnt_q))
    else $error("walk step count out of range");

  // Fire results per tick stay within the result limit.
  a_fire_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fired_q <= ptt_pkg::FIRE_W'(ptt_pkg::MAX_RESULTS))
    else $error("too many fire results in one tick");

  // The closing cycle of a walk emits a final result and frees the block.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptt_pkg::ST_DONE) |=> (out_v_q && last_q && state_q == ptt_pkg::ST_IDLE))
    else $error("walk ended without a final result");

endmodule

// ===== tb/periodic_timer_table_tb.sv =====
// Self-checking testbench for the periodic timer table: directed table, random traffic, checker.
module periodic_timer_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMERS      = 16;
  // The func encoding left free by the package; the block must drop such items.
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  // Random add, tick and query items per phase; four phases plus the directed table give 460.
  localparam int unsigned PHASE_ITEMS = 109;
  // Quiet cycles tolerated before the run is declared hung. A full walk, the
  // settle time before a register write and a run of sender gaps all stay far below.
  localparam int unsigned STALL_LIMIT = 2000;
  // The longest walk plus a little extra, waited out before touching wait_cap.
  localparam int unsigned SETTLE_CYCLES = TIMERS + 4;

  // One command as it goes on the input ports.
  typedef struct {
    logic [1:0]                    func;
    logic [ptt_pkg::MINUTES_W-1:0] minutes;
    logic                          periodic;
    logic [ptt_pkg::TAG_W-1:0]     tag;
  } timer_cmd_t;

  // One strobed result of the block.
  typedef struct {
    ptt_pkg::kind_e            kind;
    logic [ptt_pkg::TAG_W-1:0] tag;
    logic [ptt_pkg::CAP_W-1:0] wait_s;
    logic                      last;
  } timer_event_t;

  // How a row of the directed table is checked: by the predictor, against one
  // result typed into the row, or by expecting nothing at all.
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_ONE,
    CHK_SILENT
  } row_check_e;

  typedef struct {
    logic [1:0]                    func;
    logic [ptt_pkg::MINUTES_W-1:0] minutes;
    logic                          periodic;
    logic [ptt_pkg::TAG_W-1:0]     tag;
    row_check_e                    chk;
    ptt_pkg::kind_e                kind;
    logic [ptt_pkg::CAP_W-1:0]     wait_s;
  } dir_row_t;

  // Directed table. The fill section loads the list to exactly TIMERS entries so
  // that the next add reports a full list and the following tick fires all of
  // them at once: the largest burst of fire results a single tick can give.
  dir_row_t dir_rows [24] = '{
    // After reset: empty list, query reports the reset cap, tick finds nothing.
    '{ptt_pkg::FUNC_QUERY, 16'h0000, 1'b0, 8'h00, CHK_ONE, ptt_pkg::KIND_WAIT,
      ptt_pkg::DEFAULT_CAP},
    '{ptt_pkg::FUNC_TICK, 16'h0000, 1'b0, 8'h00, CHK_ONE, ptt_pkg::KIND_NONE, 16'd0},
    // Unused func code with every field high: no result, no state change.
    '{FUNC_UNUSED, 16'hFFFF, 1'b1, 8'hFF, CHK_SILENT, ptt_pkg::KIND_NONE, 16'd0},
    // Field extremes on add.
    '{ptt_pkg::FUNC_ADD, 16'hFFFF, 1'b1, 8'hFF, CHK_ONE, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h0000, 1'b0, 8'h00, CHK_ONE, ptt_pkg::KIND_ADDED, 16'd0},
    // Fill the rest of the list; one short periodic timer keeps coming back.
    '{ptt_pkg::FUNC_ADD, 16'h0001, 1'b1, 8'h01, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h8000, 1'b0, 8'h02, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h0001, 1'b0, 8'h04, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h5555, 1'b0, 8'h08, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'hAAAA, 1'b0, 8'h10, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h0002, 1'b0, 8'h20, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h00FF, 1'b0, 8'h40, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'hFF00, 1'b0, 8'h80, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h0003, 1'b0, 8'hFE, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h7FFF, 1'b0, 8'h7F, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h1234, 1'b0, 8'hAA, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h0F0F, 1'b0, 8'h55, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h0000, 1'b0, 8'h3C, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    '{ptt_pkg::FUNC_ADD, 16'h0004, 1'b0, 8'hC3, CHK_PREDICT, ptt_pkg::KIND_ADDED, 16'd0},
    // Seventeenth add: list full.
    '{ptt_pkg::FUNC_ADD, 16'h0001, 1'b0, 8'h99, CHK_ONE, ptt_pkg::KIND_FULL, 16'd0},
    // Fire all sixteen, drop the one-shots, then look at the survivors.
    '{ptt_pkg::FUNC_TICK, 16'h0000, 1'b0, 8'h00, CHK_PREDICT, ptt_pkg::KIND_NONE, 16'd0},
    '{ptt_pkg::FUNC_QUERY, 16'h0000, 1'b0, 8'h00, CHK_PREDICT, ptt_pkg::KIND_WAIT, 16'd0},
    '{ptt_pkg::FUNC_TICK, 16'h0000, 1'b0, 8'h00, CHK_PREDICT, ptt_pkg::KIND_NONE, 16'd0},
    '{ptt_pkg::FUNC_QUERY, 16'h0000, 1'b0, 8'h00, CHK_PREDICT, ptt_pkg::KIND_WAIT, 16'd0}
  };

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          start           = 1'b0;
  logic                          busy;
  logic [1:0]                    func_i          = ptt_pkg::FUNC_QUERY;
  logic [ptt_pkg::MINUTES_W-1:0] delay_minutes_i = '0;
  logic                          repeat_timer_i  = 1'b0;
  logic [ptt_pkg::TAG_W-1:0]     timer_tag_i     = '0;
  logic                          cfg_we_i        = 1'b0;
  logic [ptt_pkg::CAP_W-1:0]     cfg_data_i      = '0;
  logic                          result_valid_o;
  logic [2:0]                    kind_o;
  logic [ptt_pkg::TAG_W-1:0]     fired_tag_o;
  logic [ptt_pkg::CAP_W-1:0]     wait_seconds_o;
  logic                          last_o;

  // Shadow copy of the timer list, the clock and the cap.
  logic [ptt_pkg::NOW_W-1:0]    sched_deadline [TIMERS];
  logic [ptt_pkg::PERIOD_W-1:0] sched_period   [TIMERS];
  logic                         sched_periodic [TIMERS];
  logic [ptt_pkg::TAG_W-1:0]    sched_tag      [TIMERS];
  int unsigned                  sched_count  = 0;
  logic [ptt_pkg::NOW_W-1:0]    sched_now    = '0;
  logic [ptt_pkg::CAP_W-1:0]    wait_limit   = ptt_pkg::DEFAULT_CAP;

  // Results owed by the block, oldest first.
  timer_event_t timer_events_q [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  bit          sender_idles   = 1'b1;

  periodic_timer_table #(
    .TIMERS(TIMERS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .delay_minutes_i(delay_minutes_i),
    .repeat_timer_i (repeat_timer_i),
    .timer_tag_i    (timer_tag_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .fired_tag_o    (fired_tag_o),
    .wait_seconds_o (wait_seconds_o),
    .last_o         (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Append one result to the tail of a queue of owed results.
  function automatic void queue_event(ref timer_event_t evs[$],
                                      input ptt_pkg::kind_e kind,
                                      input logic [ptt_pkg::TAG_W-1:0] tag,
                                      input logic [ptt_pkg::CAP_W-1:0] wait_s,
                                      input logic last);
    timer_event_t ev;
    ev.kind   = kind;
    ev.tag    = tag;
    ev.wait_s = wait_s;
    ev.last   = last;
    evs.insert(evs.size(), ev);
  endfunction

  // Work out the results of one accepted command and advance the shadow list.
  function automatic void predict_timer_events(input timer_cmd_t cmd,
                                               ref timer_event_t evs[$]);
    int unsigned               wr;
    bit                        keep;
    logic [ptt_pkg::NOW_W-1:0] best;
    logic [ptt_pkg::NOW_W-1:0] gap;
    evs.delete();
    case (cmd.func)
      ptt_pkg::FUNC_ADD: begin
        if (sched_count >= TIMERS) begin
          queue_event(evs, ptt_pkg::KIND_FULL, '0, '0, 1'b0);
        end else begin
          // A new timer is due at once.
          sched_deadline[sched_count] = '0;
          sched_period[sched_count]   = ptt_pkg::PERIOD_W'(cmd.minutes) *
                                        ptt_pkg::PERIOD_W'(ptt_pkg::SEC_PER_MIN);
          sched_periodic[sched_count] = cmd.periodic;
          sched_tag[sched_count]      = cmd.tag;
          sched_count++;
          queue_event(evs, ptt_pkg::KIND_ADDED, '0, '0, 1'b0);
        end
      end
      ptt_pkg::FUNC_TICK: begin
        sched_now = sched_now + 1'b1;
        wr = 0;
        // Walk in list order; fire what is due, reschedule periodics, close up
        // the gaps left by one-shots while keeping order.
        for (int unsigned rd = 0; rd < sched_count; rd++) begin
          keep = 1'b1;
          if (evs.size() < ptt_pkg::MAX_RESULTS && sched_deadline[rd] <= sched_now) begin
            queue_event(evs, ptt_pkg::KIND_FIRED, sched_tag[rd], '0, 1'b0);
            if (sched_periodic[rd])
              sched_deadline[rd] = sched_now + sched_period[rd];
            else
              keep = 1'b0;
          end
          if (keep) begin
            sched_deadline[wr] = sched_deadline[rd];
            sched_period[wr]   = sched_period[rd];
            sched_periodic[wr] = sched_periodic[rd];
            sched_tag[wr]      = sched_tag[rd];
            wr++;
          end
        end
        sched_count = wr;
        if (evs.size() == 0)
          queue_event(evs, ptt_pkg::KIND_NONE, '0, '0, 1'b0);
      end
      ptt_pkg::FUNC_QUERY: begin
        gap = ptt_pkg::NOW_W'(wait_limit);
        if (sched_count > 0) begin
          best = '1;
          for (int unsigned i = 0; i < sched_count; i++)
            if (sched_deadline[i] < best)
              best = sched_deadline[i];
          // Overdue timers clamp to zero; long waits clamp to the cap.
          gap = (best > sched_now) ? best - sched_now : '0;
          if (gap > ptt_pkg::NOW_W'(wait_limit))
            gap = ptt_pkg::NOW_W'(wait_limit);
        end
        queue_event(evs, ptt_pkg::KIND_WAIT, '0, ptt_pkg::CAP_W'(gap), 1'b0);
      end
      default: begin
      end
    endcase
    if (evs.size() > 0)
      evs[evs.size() - 1].last = 1'b1;
  endfunction

  // Build a command with random content. Adds mostly use short periods so that
  // periodic timers come due again within a run; periodics are held back once
  // ten sit in the list, since they never leave it and would lock it full.
  function automatic timer_cmd_t make_cmd(input logic [1:0] func);
    timer_cmd_t  cmd;
    int unsigned held_periodic;
    held_periodic = 0;
    for (int unsigned i = 0; i < sched_count; i++)
      held_periodic += sched_periodic[i];
    cmd.func     = func;
    cmd.tag      = ptt_pkg::TAG_W'($urandom_range(0, 255));
    cmd.periodic = 1'($urandom_range(0, 1));
    cmd.minutes  = ptt_pkg::MINUTES_W'($urandom_range(0, 65535));
    if (func == ptt_pkg::FUNC_ADD) begin
      cmd.periodic = (held_periodic < 10) && ($urandom_range(0, 4) == 0);
      // Keep periodics off a zero period; such a timer would fire on every tick.
      if ($urandom_range(0, 9) < 7)
        cmd.minutes = cmd.periodic ? ptt_pkg::MINUTES_W'($urandom_range(1, 3))
                                   : ptt_pkg::MINUTES_W'($urandom_range(0, 3));
    end
    return cmd;
  endfunction

  // Present one command and hold it until the block takes it. Busy is sampled at
  // the falling edge, so the decision never races the rising edge. Start is
  // left high on return; the next call either reuses it or drops it.
  task automatic send_cmd(input timer_cmd_t cmd, ref timer_event_t evs[$]);
    bit taken;
    while (sender_idles && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    func_i          <= cmd.func;
    delay_minutes_i <= cmd.minutes;
    repeat_timer_i  <= cmd.periodic;
    timer_tag_i     <= cmd.tag;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    predict_timer_events(cmd, evs);
  endtask

  task automatic issue_cmd(input timer_cmd_t cmd);
    timer_event_t evs[$];
    send_cmd(cmd, evs);
    foreach (evs[i])
      timer_events_q.insert(timer_events_q.size(), evs[i]);
  endtask

  // Drop start, wait for every owed result, then wait out the settle time, since an
  // ignored item leaves no result to wait for.
  task automatic drain_events();
    start <= 1'b0;
    while (timer_events_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_wait_cap(input logic [ptt_pkg::CAP_W-1:0] cap);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    wait_limit = cap;
    cfg_we_i   <= 1'b0;
  endtask

  initial begin : stimulus
    timer_cmd_t                cmd;
    timer_event_t              evs[$];
    logic [ptt_pkg::CAP_W-1:0] cap_plan [4];
    int unsigned               sent;
    int unsigned               burst;
    int unsigned               pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (dir_rows[r]) begin
      cmd = '{dir_rows[r].func, dir_rows[r].minutes, dir_rows[r].periodic, dir_rows[r].tag};
      send_cmd(cmd, evs);
      case (dir_rows[r].chk)
        CHK_PREDICT: foreach (evs[i]) timer_events_q.insert(timer_events_q.size(), evs[i]);
        CHK_ONE:     queue_event(timer_events_q, dir_rows[r].kind, '0, dir_rows[r].wait_s,
                                 1'b1);
        default: begin
        end
      endcase
    end

    // Random traffic in four phases, each under its own cap: all ones, zero,
    // a random value and one minute, which sits right on the shortest period.
    cap_plan = '{16'hFFFF, 16'h0000, ptt_pkg::CAP_W'($urandom_range(0, 65535)), 16'd60};
    for (int phase = 0; phase < 4; phase++) begin
      drain_events();
      write_wait_cap(cap_plan[phase]);
      // The second phase runs back to back with no sender gaps.
      sender_idles = (phase != 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          // Add bursts; the long ones push the list to full.
          burst = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 18) : $urandom_range(1, 4);
          if (burst > PHASE_ITEMS - sent)
            burst = PHASE_ITEMS - sent;
          repeat (burst) issue_cmd(make_cmd(ptt_pkg::FUNC_ADD));
          sent += burst;
        end else if (pick < 65) begin
          // Tick runs; the long ones carry periodic timers past their next deadline.
          burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 8);
          if (burst > PHASE_ITEMS - sent)
            burst = PHASE_ITEMS - sent;
          repeat (burst) issue_cmd(make_cmd(ptt_pkg::FUNC_TICK));
          sent += burst;
        end else if (pick < 90) begin
          issue_cmd(make_cmd(ptt_pkg::FUNC_QUERY));
          sent++;
        end else if (pick < 97) begin
          // Noise: an unused func code with random fields.
          issue_cmd(make_cmd(FUNC_UNUSED));
        end else begin
          // Hold off until the block has delivered everything owed.
          drain_events();
        end
      end
    end

    drain_events();
    if (mismatch_count == 0)
      $display("periodic_timer_table_tb: PASS");
    else
      $display("periodic_timer_table_tb: FAIL");
    $finish;
  end

  // Compare each strobed result with the oldest owed one. Sampled mid-cycle,
  // while the strobe and fields are stable.
  always @(negedge clk_i) begin : check_results
    timer_event_t owed;
    if (rst_ni && result_valid_o) begin
      if (timer_events_q.size() == 0) begin
        $error("result with none owed: kind %0d tag %0d wait %0d last %0b",
               kind_o, fired_tag_o, wait_seconds_o, last_o);
        mismatch_count++;
      end else begin
        owed = timer_events_q.pop_front();
        if (kind_o !== owed.kind) begin
          $error("kind: expected %0d, got %0d", owed.kind, kind_o);
          mismatch_count++;
        end
        if (fired_tag_o !== owed.tag) begin
          $error("fired_tag: expected %0d, got %0d", owed.tag, fired_tag_o);
          mismatch_count++;
        end
        if (wait_seconds_o !== owed.wait_s) begin
          $error("wait_seconds: expected %0d, got %0d", owed.wait_s, wait_seconds_o);
          mismatch_count++;
        end
        if (last_o !== owed.last) begin
          $error("last: expected %0b, got %0b", owed.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // Hang detection: count cycles in which neither an item nor a result moves.
  always @(negedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("periodic_timer_table_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
